FILE: rtl/sobhf_pkg.sv
// Shared types and constants for the horizontal Sobel edge filter.
// No dependencies.
package sobhf_pkg;

	localparam int DEF_MAX_WIDTH = 2048;

	localparam int FW_W   = 12;
	localparam int FH_W   = 16;
	localparam int CFG_W  = 16;
	localparam int COMP_W = 8;
	localparam int SUM_W  = 10;
	localparam int ROW_W  = 16;
	localparam int COL_W  = 11;
	localparam int GRAD_W = 13;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);
	localparam int MIN_DIM = 3;

	// window columns kept in the cell chain (middle column and left column)
	localparam int NUM_CELLS = 2;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef logic [SUM_W-1:0] sum_t;

	typedef struct packed {
		sum_t top;
		sum_t mid;
		sum_t bot;
	} win_col_t;

endpackage

FILE: rtl/sobhf_if.sv
// Valid/ready channel interfaces for pixel requests and edge results.
// Depends on sobhf_pkg.
interface sobhf_pix_if;
	import sobhf_pkg::*;
	logic              valid;
	logic              ready;
	logic [COMP_W-1:0] red;
	logic [COMP_W-1:0] green;
	logic [COMP_W-1:0] blue;
	modport source (output valid, red, green, blue, input ready);
	modport sink   (input valid, red, green, blue, output ready);
endinterface

interface sobhf_res_if;
	import sobhf_pkg::*;
	logic             valid;
	logic             ready;
	logic [7:0]       edge_value;
	logic [ROW_W-1:0] center_row;
	logic [COL_W-1:0] center_col;
	logic             frame_done;
	modport source (output valid, edge_value, center_row, center_col, frame_done, input ready);
	modport sink   (input valid, edge_value, center_row, center_col, frame_done, output ready);
endinterface

FILE: rtl/sobel_horizontal_edge_filter_top.sv
// Horizontal 3x3 Sobel edge filter over a raster stream of RGB pixels.
// Throughput: one pixel per cycle unless the result output stalls; the line store has
// at most one read and one write each cycle. A taken request is registered in stage 1,
// then in the result register; a stalled result holds stage 1, then the pixel input.
// Reset: counters, window cells and handshake state clear; width 640, height 480.
// Line store contents are undefined after reset and need no clearing pass.
module sobel_horizontal_edge_filter_top #(
	parameter int MAX_WIDTH = sobhf_pkg::DEF_MAX_WIDTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  sobhf_pkg::cfg_idx_t       cfg_idx,
	input  logic [sobhf_pkg::CFG_W-1:0] cfg_data,
	sobhf_pix_if.sink                 pix,
	sobhf_res_if.source               res
);
	import sobhf_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic [CW-1:0]   col_q;
	logic [ROW_W-1:0] row_q;

	logic [WW-1:0]   eff_w;
	logic [FH_W-1:0] eff_h;
	logic [WW-1:0]   col_inc;
	logic [ROW_W:0]  row_inc;
	logic            row_end;
	logic [31:0]     col_m1;
	logic [31:0]     row_m1;

	logic            accept;
	logic            adv1;
	logic            adv2;

	logic             valid_s1;
	sum_t             sum_s1;
	logic [CW-1:0]    addr_s1;
	logic             emit_s1;
	logic             done_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] ocol_s1;

	logic [2*SUM_W-1:0] rd_data;
	win_col_t           chain [NUM_CELLS+1];
	win_col_t           left;
	logic signed [GRAD_W-1:0] grad;
	logic [7:0]         edge_s1;

	logic             res_valid_q;
	logic [7:0]       edge_q;
	logic [ROW_W-1:0] row_out_q;
	logic [COL_W-1:0] col_out_q;
	logic             done_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (frame_width_q < FW_W'(MIN_DIM)) begin
			eff_w = WW'(MIN_DIM);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(frame_width_q);
		end
		if (frame_height_q < FH_W'(MIN_DIM)) begin
			eff_h = FH_W'(MIN_DIM);
		end else begin
			eff_h = frame_height_q;
		end
	end

	assign col_inc = WW'(col_q) + WW'(1);
	assign row_inc = (ROW_W+1)'(row_q) + (ROW_W+1)'(1);
	assign row_end = col_inc >= eff_w;
	assign col_m1  = 32'(col_q) - 32'd1;
	assign row_m1  = 32'(row_q) - 32'd1;

	// handshake
	assign adv2      = !res_valid_q || res.ready;
	assign adv1      = valid_s1 && (!emit_s1 || adv2);
	assign pix.ready = !valid_s1 || adv1;
	assign accept    = pix.valid && pix.ready;

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				if (row_inc >= (ROW_W+1)'(eff_h)) begin
					row_q <= '0;
				end else begin
					row_q <= row_inc[ROW_W-1:0];
				end
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// stage 1: pixel sum, line store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			emit_s1  <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				emit_s1  <= (row_q >= ROW_W'(2)) && (col_q >= CW'(2));
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_s1  <= SUM_W'(pix.red) + SUM_W'(pix.green) + SUM_W'(pix.blue);
			addr_s1 <= col_q;
			done_s1 <= (row_inc >= (ROW_W+1)'(eff_h)) && row_end;
			row_s1  <= row_m1[ROW_W-1:0];
			ocol_s1 <= col_m1[COL_W-1:0];
		end
	end

	sobhf_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_store (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (adv1),
		.wr_addr (addr_s1),
		.wr_data ({rd_data[SUM_W-1:0], sum_s1})
	);

	// window: new column enters cell 0, cell 1 holds the column that becomes the left edge
	assign chain[0] = '{top: rd_data[2*SUM_W-1:SUM_W], mid: rd_data[SUM_W-1:0], bot: sum_s1};

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		sobhf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (adv1),
			.col_in  (chain[i]),
			.col_out (chain[i+1])
		);
	end

	assign left = chain[NUM_CELLS];

	always_comb begin
		grad = $signed(GRAD_W'(chain[0].top) - GRAD_W'(left.top)
			+ ((GRAD_W'(chain[0].mid) - GRAD_W'(left.mid)) << 1)
			+ GRAD_W'(chain[0].bot) - GRAD_W'(left.bot));
		if (grad <= $signed(GRAD_W'(0))) begin
			edge_s1 = 8'd0;
		end else if (grad >= $signed(GRAD_W'(128))) begin
			edge_s1 = 8'd255;
		end else begin
			edge_s1 = {grad[6:0], 1'b0};
		end
	end

	// stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv2) begin
			res_valid_q <= adv1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && adv1 && emit_s1) begin
			edge_q    <= edge_s1;
			row_out_q <= row_s1;
			col_out_q <= ocol_s1;
			done_q    <= done_s1;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.edge_value = edge_q;
	assign res.center_row = row_out_q;
	assign res.center_col = col_out_q;
	assign res.frame_done = done_q;

endmodule

FILE: rtl/sobhf_cell.sv
// One window cell: holds a column of three pixel sums, passes it on when shifted.
// Depends on sobhf_pkg.
module sobhf_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               shift,
	input  sobhf_pkg::win_col_t col_in,
	output sobhf_pkg::win_col_t col_out
);
	import sobhf_pkg::*;

	win_col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

FILE: rtl/sobhf_line_store.sv
// Line store: two rows of pixel sums packed per column, registered read.
// Depends on sobhf_pkg.
module sobhf_line_store #(
	parameter int DEPTH = sobhf_pkg::DEF_MAX_WIDTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [2*sobhf_pkg::SUM_W-1:0] rd_data,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [2*sobhf_pkg::SUM_W-1:0] wr_data
);
	import sobhf_pkg::*;

	logic [2*SUM_W-1:0] mem [DEPTH];
	logic [2*SUM_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sim/sobel_horizontal_edge_filter_top_tb.sv
// Self-checking testbench for the horizontal Sobel edge filter: feeds pixel requests,
// predicts every edge result and compares each taken result field by field.
// Depends on sobhf_pkg, the sobhf_pix_if/sobhf_res_if interfaces and the filter top.
module sobel_horizontal_edge_filter_top_tb;
	import sobhf_pkg::*;

	localparam int MAXW         = DEF_MAX_WIDTH;
	localparam int RANDOM_ITEMS = 1300;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_CYCLES = 6;
	localparam int LIMIT        = 400000;

	typedef struct packed {
		logic [COMP_W-1:0] red;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [7:0]       edge_value;
		logic [ROW_W-1:0] center_row;
		logic [COL_W-1:0] center_col;
		logic             frame_done;
	} edge_res_t;

	// 5x4 frame: hard steps both ways, single-bit and alternating patterns
	localparam logic [23:0] STEP_FRAME [20] = '{
		24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h010101,
		24'h000000, 24'h808080, 24'hFFFFFF, 24'h55AA55, 24'h000000,
		24'h000000, 24'h000000, 24'hFFFFFF, 24'hAAAA55, 24'hFF0000,
		24'h102030, 24'h112131, 24'h122232, 24'h00FF00, 24'h0000FF
	};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	cfg_idx_t         cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	sobhf_pix_if pix_ch();
	sobhf_res_if res_ch();

	sobel_horizontal_edge_filter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.pix(pix_ch),
		.res(res_ch)
	);

	always #6 clk = ~clk;

	// predictor state
	logic [FW_W-1:0] fw_reg = FRAME_WIDTH_RST;
	logic [FH_W-1:0] fh_reg = FRAME_HEIGHT_RST;
	bit [SUM_W-1:0]  upper_sums [MAXW];
	bit [SUM_W-1:0]  middle_sums [MAXW];
	bit [SUM_W-1:0]  win_sums [3][3];
	int unsigned     col_pos = 0;
	int unsigned     row_pos = 0;

	pixel_t      pixel_q[$];
	edge_res_t   pending_edges[$];
	pixel_t      drive_px;
	edge_res_t   want;
	int unsigned send_idle_pct = 6;
	int unsigned recv_idle_pct = 46;
	logic        hold_req = 1'b0;
	logic        hold_used;
	int unsigned hold_cnt;
	int unsigned cycle = 0;
	int unsigned mismatches = 0;

	function automatic int unsigned eff_width();
		if (fw_reg < MIN_DIM) return MIN_DIM;
		if (fw_reg > MAXW) return MAXW;
		return fw_reg;
	endfunction

	function automatic int unsigned eff_height();
		if (fh_reg < MIN_DIM) return MIN_DIM;
		return fh_reg;
	endfunction

	function automatic int unsigned pixels_to_frame_end();
		int unsigned c = col_pos;
		int unsigned r = row_pos;
		int unsigned n = 0;
		do begin
			n++;
			c++;
			if (c >= eff_width()) begin
				c = 0;
				r++;
				if (r >= eff_height()) r = 0;
			end
		end while (c != 0 || r != 0);
		return n;
	endfunction

	task automatic predict_edge(input pixel_t px);
		int unsigned w;
		int unsigned h;
		bit [SUM_W-1:0] s;
		bit [SUM_W-1:0] top;
		bit [SUM_W-1:0] mid;
		int grad;
		edge_res_t e;
		w = eff_width();
		h = eff_height();
		s = SUM_W'(px.red) + SUM_W'(px.green) + SUM_W'(px.blue);
		top = '0;
		mid = '0;
		if (col_pos < MAXW) begin
			top = upper_sums[col_pos];
			mid = middle_sums[col_pos];
			upper_sums[col_pos] = mid;
			middle_sums[col_pos] = s;
		end
		for (int i = 0; i < 3; i++) begin
			win_sums[i][0] = win_sums[i][1];
			win_sums[i][1] = win_sums[i][2];
		end
		win_sums[0][2] = top;
		win_sums[1][2] = mid;
		win_sums[2][2] = s;
		if (row_pos >= 2 && col_pos >= 2) begin
			grad = (int'(win_sums[0][2]) - int'(win_sums[0][0]))
				+ 2 * (int'(win_sums[1][2]) - int'(win_sums[1][0]))
				+ (int'(win_sums[2][2]) - int'(win_sums[2][0]));
			grad = 2 * grad;
			if (grad < 0) grad = 0;
			if (grad > 255) grad = 255;
			e.edge_value = 8'(grad);
			e.center_row = ROW_W'(row_pos - 1);
			e.center_col = COL_W'(col_pos - 1);
			e.frame_done = (row_pos + 1 >= h) && (col_pos + 1 >= w);
			pending_edges.push_back(e);
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h) row_pos = 0;
		end
	endtask

	task automatic note_mismatch(input string msg);
		mismatches++;
		$display("mismatch at cycle %0d: %s", cycle, msg);
	endtask

	// spread 255 gives full-range pixels, small spread gives low-contrast ones
	task automatic push_pixels(input int unsigned n, input int unsigned spread);
		pixel_t px;
		int unsigned br;
		int unsigned bg;
		int unsigned bb;
		br = $urandom_range(0, 255 - spread);
		bg = $urandom_range(0, 255 - spread);
		bb = $urandom_range(0, 255 - spread);
		repeat (n) begin
			px.red   = COMP_W'(br + $urandom_range(0, spread));
			px.green = COMP_W'(bg + $urandom_range(0, spread));
			px.blue  = COMP_W'(bb + $urandom_range(0, spread));
			pixel_q.push_back(px);
		end
	endtask

	task automatic set_frame(input logic [CFG_W-1:0] w_data, input logic [CFG_W-1:0] h_data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= REG_FRAME_WIDTH;
		cfg_data <= w_data;
		fw_reg = w_data[FW_W-1:0];
		@(posedge clk);
		cfg_idx <= REG_FRAME_HEIGHT;
		cfg_data <= h_data;
		fh_reg = h_data[FH_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_quiet();
		do @(negedge clk);
		while (pixel_q.size() != 0 || pix_ch.valid || pending_edges.size() != 0);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	// pixel request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
			pix_ch.red <= '0;
			pix_ch.green <= '0;
			pix_ch.blue <= '0;
		end else begin
			if (pix_ch.valid && pix_ch.ready)
				predict_edge({pix_ch.red, pix_ch.green, pix_ch.blue});
			if (!pix_ch.valid || pix_ch.ready) begin
				if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					drive_px = pixel_q.pop_front();
					pix_ch.valid <= 1'b1;
					pix_ch.red <= drive_px.red;
					pix_ch.green <= drive_px.green;
					pix_ch.blue <= drive_px.blue;
				end else begin
					pix_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, fired once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
			hold_used <= 1'b0;
		end else if (hold_req && !hold_used) begin
			hold_cnt <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (pending_edges.size() == 0) begin
					note_mismatch($sformatf("unexpected result row %0d col %0d",
						res_ch.center_row, res_ch.center_col));
				end else begin
					want = pending_edges.pop_front();
					if (res_ch.edge_value !== want.edge_value)
						note_mismatch($sformatf("edge_value %0d, want %0d (row %0d col %0d)",
							res_ch.edge_value, want.edge_value, want.center_row,
							want.center_col));
					if (res_ch.center_row !== want.center_row)
						note_mismatch($sformatf("center_row %0d, want %0d",
							res_ch.center_row, want.center_row));
					if (res_ch.center_col !== want.center_col)
						note_mismatch($sformatf("center_col %0d, want %0d",
							res_ch.center_col, want.center_col));
					if (res_ch.frame_done !== want.frame_done)
						note_mismatch($sformatf("frame_done %b, want %b (row %0d col %0d)",
							res_ch.frame_done, want.frame_done, want.center_row,
							want.center_col));
				end
			end
			res_ch.ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) cycle <= cycle + 1;

	initial begin
		while (cycle < LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int unsigned random_sent;
		int unsigned n;
		int unsigned k;
		int unsigned w;
		int unsigned h;
		int unsigned spread;
		random_sent = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_FRAME_WIDTH;
		cfg_data = '0;
		pix_ch.valid = 1'b0;
		pix_ch.red = '0;
		pix_ch.green = '0;
		pix_ch.blue = '0;
		res_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// upper bits of the width write fall outside the 12-bit register
		set_frame({4'hA, 12'd5}, 16'd4);
		foreach (STEP_FRAME[i]) pixel_q.push_back(STEP_FRAME[i]);
		wait_quiet();

		// both sizes below minimum; one-step gradient gives an unclamped value
		set_frame(16'd0, 16'd1);
		repeat (3) begin
			pixel_q.push_back(24'h404040);
			pixel_q.push_back(24'h404040);
			pixel_q.push_back(24'h414040);
		end
		wait_quiet();

		while (random_sent < RANDOM_ITEMS) begin
			if (random_sent >= 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (random_sent >= RANDOM_ITEMS / 3) begin
				send_idle_pct = 46;
				recv_idle_pct = 6;
			end
			case ($urandom_range(0, 9))
				0: w = $urandom_range(0, 2);
				1: w = $urandom_range(100, 300);
				default: w = $urandom_range(3, 24);
			endcase
			if (w >= 100)
				h = $urandom_range(3, 4);
			else if ($urandom_range(0, 7) == 0)
				h = $urandom_range(0, 2);
			else
				h = $urandom_range(3, 8);
			spread = ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(0, 12);
			set_frame({4'($urandom), 12'(w)}, 16'(h));
			n = eff_width() * eff_height();
			if ($urandom_range(0, 4) == 0) begin
				// pause mid-frame, shrink width and/or change height, then finish the frame
				k = $urandom_range(1, n - 1);
				push_pixels(k, spread);
				wait_quiet();
				set_frame({4'($urandom), 12'($urandom_range(0, eff_width()))},
					16'($urandom_range(0, 12)));
				n = k + pixels_to_frame_end();
				push_pixels(n - k, spread);
			end else begin
				push_pixels(n, spread);
			end
			random_sent += n;
			wait_quiet();
		end

		set_frame(16'd12, 16'd10);
		hold_req = 1'b1;
		push_pixels(120, 20);
		wait_quiet();

		// out-of-range width clamps to the line store depth; leave that row early
		set_frame(16'hFFFF, 16'hFFFF);
		push_pixels(40, 40);
		wait_quiet();
		set_frame(16'h0007, 16'hFFFF);
		push_pixels(30, 255);
		wait_quiet();
		set_frame(16'h0007, 16'h0001);
		push_pixels(pixels_to_frame_end(), 255);
		wait_quiet();

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: files.f
rtl/sobhf_pkg.sv
rtl/sobhf_if.sv
rtl/sobhf_cell.sv
rtl/sobhf_line_store.sv
rtl/sobel_horizontal_edge_filter_top.sv
sim/sobel_horizontal_edge_filter_top_tb.sv
